// ===== rtl/core/hses_pkg.sv =====
`default_nettype none
package hses_pkg;

   // Sizes of the set
   localparam int MAX_ENTRIES = 1024;
   localparam int ENTRY_SPACE = 4096;

   // Field widths
   localparam int OP_W     = 3;
   localparam int ENTRY_W  = 12;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int SLOT_W   = $clog2(MAX_ENTRIES);
   localparam int SPACE_W  = $clog2(ENTRY_SPACE);

   // Operation codes
   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
   localparam logic [OP_W-1:0] OP_FIRST = 3'd2;
   localparam logic [OP_W-1:0] OP_LAST  = 3'd3;
   localparam logic [OP_W-1:0] OP_PREV  = 3'd4;
   localparam logic [OP_W-1:0] OP_NEXT  = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NONE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUP   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

   // Write port of the order store
   typedef struct packed {
      logic               we;
      logic [SLOT_W-1:0]  addr;
      logic [ENTRY_W-1:0] data;
   } ord_wr_type;

   // Write port of the position table
   typedef struct packed {
      logic               we;
      logic [SPACE_W-1:0] addr;
      logic [SLOT_W-1:0]  data;
   } pos_wr_type;

endpackage
`default_nettype wire

// ===== rtl/core/hses_order_mem.sv =====
`default_nettype none
module hses_order_mem (
   input  wire logic                       clock,
   input  wire hses_pkg::ord_wr_type       wr,
   input  wire logic [hses_pkg::SLOT_W-1:0]  rd_addr_a,
   input  wire logic [hses_pkg::SLOT_W-1:0]  rd_addr_b,
   output logic      [hses_pkg::ENTRY_W-1:0] rd_data_a,
   output logic      [hses_pkg::ENTRY_W-1:0] rd_data_b
);
   import hses_pkg::*;

   logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_a_ff;
   logic [ENTRY_W-1:0] rd_data_b_ff;

   // one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hses_pos_mem.sv =====
`default_nettype none
module hses_pos_mem (
   input  wire logic                        clock,
   input  wire hses_pkg::pos_wr_type        wr,
   input  wire logic [hses_pkg::SPACE_W-1:0] rd_addr,
   output logic      [hses_pkg::SLOT_W-1:0]  rd_data
);
   import hses_pkg::*;

   logic [SLOT_W-1:0] mem [ENTRY_SPACE];
   logic [SLOT_W-1:0] rd_data_ff;

   // one write, one registered read
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/heapsorted_entry_set_top.sv =====
// Channel   Handshake         Ports
// request   start, busy       req_op, req_entry
// response  rsp_valid strobe  rsp_status, rsp_entry_out, rsp_member_count
//
// A word is taken when start is high and busy low; one response word follows.
// A query on a set of two or more entries changed by an add first heapsorts the
// order store through its two-read memory, a sift step per level after loading
// each root or swap, then rewrites the position table one entry at a time.
// After reset the position table is swept with busy high. The receiver cannot
// stall responses.
`default_nettype none
module heapsorted_entry_set_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [hses_pkg::OP_W-1:0]     req_op,
   input  wire logic [hses_pkg::ENTRY_W-1:0]  req_entry,
   output logic                               rsp_valid,
   output logic      [hses_pkg::STATUS_W-1:0] rsp_status,
   output logic      [hses_pkg::ENTRY_W-1:0]  rsp_entry_out,
   output logic      [hses_pkg::COUNT_W-1:0]  rsp_member_count
);
   import hses_pkg::*;

   localparam int CW = SLOT_W + 2;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_ADD_POS, S_ADD_RD, S_ADD_CHK,
      S_END_RD, S_END_OUT,
      S_NB_POS, S_NB_RD, S_NB_OUT,
      S_SD_LOAD, S_SD_LOADW, S_SD_CHK, S_SD_CMP, S_SD_NEXT,
      S_SW_RD, S_SW_WR,
      S_RB_RD, S_RB_WR
   } state_type;

   state_type            state_ff;
   logic [OP_W-1:0]      op_ff;
   logic [ENTRY_W-1:0]   entry_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 dirty_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SPACE_W-1:0]   init_ff;
   logic [COUNT_W-1:0]   k_ff;
   logic                 extract_ff;
   logic [COUNT_W-1:0]   n_sift_ff;
   logic [SLOT_W-1:0]    idx_ff;
   logic [ENTRY_W-1:0]   v_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ENTRY_W-1:0]   rsp_entry_out_ff;
   logic [COUNT_W-1:0]   rsp_member_count_ff;

   ord_wr_type           ord_wr;
   logic [SLOT_W-1:0]    ord_ra_addr;
   logic [SLOT_W-1:0]    ord_rb_addr;
   logic [ENTRY_W-1:0]   ord_ra_data;
   logic [ENTRY_W-1:0]   ord_rb_data;
   pos_wr_type           pos_wr;
   logic [SLOT_W-1:0]    pos_rdata;

   logic [CW-1:0]        child;
   logic [CW-1:0]        child_r;
   logic                 child_has;
   logic                 pick_right;
   logic [ENTRY_W-1:0]   pick_val;
   logic [CW-1:0]        pick_idx;
   logic                 add_hit;
   logic                 add_full;
   logic                 nb_hit;
   logic                 req_range;
   logic [COUNT_W-1:0]   slot_ext;

   hses_order_mem u_order (
      .clock     (clock),
      .wr        (ord_wr),
      .rd_addr_a (ord_ra_addr),
      .rd_addr_b (ord_rb_addr),
      .rd_data_a (ord_ra_data),
      .rd_data_b (ord_rb_data)
   );

   hses_pos_mem u_pos (
      .clock   (clock),
      .wr      (pos_wr),
      .rd_addr (entry_ff[SPACE_W-1:0]),
      .rd_data (pos_rdata)
   );

   // heap child selection
   assign child      = CW'({idx_ff, 1'b1});
   assign child_r    = child + CW'(1);
   assign child_has  = child < CW'(n_sift_ff);
   assign pick_right = (child_r < CW'(n_sift_ff)) && (ord_rb_data > ord_ra_data);
   assign pick_val   = pick_right ? ord_rb_data : ord_ra_data;
   assign pick_idx   = pick_right ? child_r : child;

   // membership checks (sparse set: slot below count holding the entry)
   assign slot_ext  = COUNT_W'(slot_ff);
   assign add_hit   = (slot_ext < count_ff) && (ord_ra_data == entry_ff);
   assign add_full  = count_ff >= COUNT_W'(MAX_ENTRIES);
   assign nb_hit    = add_hit;
   assign req_range = (ENTRY_W + 1)'(req_entry) >= (ENTRY_W + 1)'(ENTRY_SPACE);

   // memory addresses and writes
   always_comb begin
      ord_wr      = '0;
      pos_wr      = '0;
      ord_ra_addr = idx_ff;
      ord_rb_addr = idx_ff;
      unique case (state_ff)
         S_INIT: begin
            pos_wr.we   = 1'b1;
            pos_wr.addr = init_ff;
         end
         S_ADD_RD: ord_ra_addr = pos_rdata;
         S_ADD_CHK: begin
            if (!add_hit && !add_full) begin
               ord_wr.we   = 1'b1;
               ord_wr.addr = count_ff[SLOT_W-1:0];
               ord_wr.data = entry_ff;
               pos_wr.we   = 1'b1;
               pos_wr.addr = entry_ff[SPACE_W-1:0];
               pos_wr.data = count_ff[SLOT_W-1:0];
            end
         end
         S_END_RD: begin
            ord_ra_addr = (op_ff == OP_FIRST) ? '0 : SLOT_W'(count_ff - COUNT_W'(1));
         end
         S_NB_RD: begin
            ord_ra_addr = pos_rdata;
            ord_rb_addr = (op_ff == OP_PREV) ? pos_rdata - SLOT_W'(1)
                                             : pos_rdata + SLOT_W'(1);
         end
         S_SD_CHK: begin
            ord_ra_addr = child[SLOT_W-1:0];
            ord_rb_addr = child_r[SLOT_W-1:0];
            if (!child_has) begin
               ord_wr.we   = 1'b1;
               ord_wr.addr = idx_ff;
               ord_wr.data = v_ff;
            end
         end
         S_SD_CMP: begin
            ord_wr.we   = 1'b1;
            ord_wr.addr = idx_ff;
            ord_wr.data = (v_ff >= pick_val) ? v_ff : pick_val;
         end
         S_SW_RD: begin
            ord_ra_addr = '0;
            ord_rb_addr = SLOT_W'(k_ff - COUNT_W'(1));
         end
         S_SW_WR: begin
            ord_wr.we   = 1'b1;
            ord_wr.addr = SLOT_W'(k_ff - COUNT_W'(1));
            ord_wr.data = ord_ra_data;
         end
         S_RB_WR: begin
            pos_wr.we   = 1'b1;
            pos_wr.addr = ord_ra_data[SPACE_W-1:0];
            pos_wr.data = idx_ff;
         end
         default: ;
      endcase
   end

   // control sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_INIT;
         init_ff             <= '0;
         count_ff            <= '0;
         dirty_ff            <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         rsp_member_count_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + SPACE_W'(1);
               if (init_ff == SPACE_W'(ENTRY_SPACE - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_op;
                  entry_ff <= req_entry;
                  unique case (req_op)
                     OP_ADD, OP_PREV, OP_NEXT: begin
                        if (req_range) begin
                           rsp_valid_ff        <= 1'b1;
                           rsp_status_ff       <= ST_RANGE;
                           rsp_entry_out_ff    <= '0;
                           rsp_member_count_ff <= count_ff;
                        end else if (req_op == OP_ADD) begin
                           state_ff <= S_ADD_POS;
                        end else if (dirty_ff && count_ff >= COUNT_W'(2)) begin
                           extract_ff <= 1'b0;
                           k_ff       <= count_ff >> 1;
                           idx_ff     <= SLOT_W'((count_ff >> 1) - COUNT_W'(1));
                           n_sift_ff  <= count_ff;
                           state_ff   <= S_SD_LOAD;
                        end else if (dirty_ff) begin
                           idx_ff   <= '0;
                           state_ff <= S_RB_RD;
                        end else begin
                           state_ff <= S_NB_POS;
                        end
                     end
                     OP_FIRST, OP_LAST: begin
                        if (dirty_ff && count_ff >= COUNT_W'(2)) begin
                           extract_ff <= 1'b0;
                           k_ff       <= count_ff >> 1;
                           idx_ff     <= SLOT_W'((count_ff >> 1) - COUNT_W'(1));
                           n_sift_ff  <= count_ff;
                           state_ff   <= S_SD_LOAD;
                        end else if (dirty_ff) begin
                           idx_ff   <= '0;
                           state_ff <= S_RB_RD;
                        end else begin
                           state_ff <= S_END_RD;
                        end
                     end
                     OP_CLEAR: begin
                        count_ff            <= '0;
                        dirty_ff            <= 1'b0;
                        rsp_valid_ff        <= 1'b1;
                        rsp_status_ff       <= ST_OK;
                        rsp_entry_out_ff    <= '0;
                        rsp_member_count_ff <= '0;
                     end
                     default: begin
                        rsp_valid_ff        <= 1'b1;
                        rsp_status_ff       <= ST_OK;
                        rsp_entry_out_ff    <= '0;
                        rsp_member_count_ff <= count_ff;
                     end
                  endcase
               end
            end
            // add: slot lookup, store read, decide
            S_ADD_POS: state_ff <= S_ADD_RD;
            S_ADD_RD: begin
               slot_ff  <= pos_rdata;
               state_ff <= S_ADD_CHK;
            end
            S_ADD_CHK: begin
               rsp_valid_ff     <= 1'b1;
               rsp_entry_out_ff <= '0;
               state_ff         <= S_IDLE;
               if (add_hit) begin
                  rsp_status_ff       <= ST_DUP;
                  rsp_member_count_ff <= count_ff;
               end else if (add_full) begin
                  rsp_status_ff       <= ST_FULL;
                  rsp_member_count_ff <= count_ff;
               end else begin
                  rsp_status_ff       <= ST_OK;
                  count_ff            <= count_ff + COUNT_W'(1);
                  dirty_ff            <= 1'b1;
                  rsp_member_count_ff <= count_ff + COUNT_W'(1);
               end
            end
            // first and last
            S_END_RD: state_ff <= S_END_OUT;
            S_END_OUT: begin
               rsp_valid_ff        <= 1'b1;
               rsp_member_count_ff <= count_ff;
               state_ff            <= S_IDLE;
               if (count_ff == '0) begin
                  rsp_status_ff    <= ST_NONE;
                  rsp_entry_out_ff <= '0;
               end else begin
                  rsp_status_ff    <= ST_OK;
                  rsp_entry_out_ff <= ord_ra_data;
               end
            end
            // previous and next
            S_NB_POS: state_ff <= S_NB_RD;
            S_NB_RD: begin
               slot_ff  <= pos_rdata;
               state_ff <= S_NB_OUT;
            end
            S_NB_OUT: begin
               rsp_valid_ff        <= 1'b1;
               rsp_member_count_ff <= count_ff;
               state_ff            <= S_IDLE;
               if (!nb_hit
                   || (op_ff == OP_PREV && slot_ff == '0)
                   || (op_ff == OP_NEXT && slot_ext + COUNT_W'(1) >= count_ff)) begin
                  rsp_status_ff    <= ST_NONE;
                  rsp_entry_out_ff <= '0;
               end else begin
                  rsp_status_ff    <= ST_OK;
                  rsp_entry_out_ff <= ord_rb_data;
               end
            end
            // sift down
            S_SD_LOAD: state_ff <= S_SD_LOADW;
            S_SD_LOADW: begin
               v_ff     <= ord_ra_data;
               state_ff <= S_SD_CHK;
            end
            S_SD_CHK: begin
               state_ff <= child_has ? S_SD_CMP : S_SD_NEXT;
            end
            S_SD_CMP: begin
               if (v_ff >= pick_val) begin
                  state_ff <= S_SD_NEXT;
               end else begin
                  idx_ff   <= pick_idx[SLOT_W-1:0];
                  state_ff <= S_SD_CHK;
               end
            end
            S_SD_NEXT: begin
               if (!extract_ff) begin
                  if (k_ff == COUNT_W'(1)) begin
                     extract_ff <= 1'b1;
                     k_ff       <= count_ff;
                     state_ff   <= S_SW_RD;
                  end else begin
                     k_ff     <= k_ff - COUNT_W'(1);
                     idx_ff   <= SLOT_W'(k_ff - COUNT_W'(2));
                     state_ff <= S_SD_LOAD;
                  end
               end else if (k_ff > COUNT_W'(2)) begin
                  k_ff     <= k_ff - COUNT_W'(1);
                  state_ff <= S_SW_RD;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= S_RB_RD;
               end
            end
            // swap root with last heap slot, then sift the old last word
            S_SW_RD: state_ff <= S_SW_WR;
            S_SW_WR: begin
               v_ff      <= ord_rb_data;
               idx_ff    <= '0;
               n_sift_ff <= k_ff - COUNT_W'(1);
               state_ff  <= S_SD_CHK;
            end
            // rebuild position table
            S_RB_RD: state_ff <= S_RB_WR;
            S_RB_WR: begin
               if (COUNT_W'(idx_ff) + COUNT_W'(1) == count_ff) begin
                  dirty_ff <= 1'b0;
                  state_ff <= (op_ff == OP_FIRST || op_ff == OP_LAST) ? S_END_RD
                                                                     : S_NB_POS;
               end else begin
                  idx_ff   <= idx_ff + SLOT_W'(1);
                  state_ff <= S_RB_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_out    = rsp_entry_out_ff;
   assign rsp_member_count = rsp_member_count_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hses_checker.sv =====
`default_nettype none
module hses_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic [hses_pkg::OP_W-1:0]     req_op,
   input wire logic [hses_pkg::ENTRY_W-1:0]  req_entry,
   input wire logic                          rsp_valid,
   input wire logic [hses_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [hses_pkg::ENTRY_W-1:0]  rsp_entry_out,
   input wire logic [hses_pkg::COUNT_W-1:0]  rsp_member_count
);
   import hses_pkg::*;

   // an accepted word is followed by work or its response
   a_accept_follow: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word dropped");

   // no response strobe straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

   // failed queries carry no entry
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_entry_out == '0))
      else $error("entry on failed word");

   // member count bounded
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_member_count <= COUNT_W'(MAX_ENTRIES)))
      else $error("member count over capacity");

   // count only moves with a response
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> $stable(rsp_member_count))
      else $error("member count moved without response");

endmodule

bind heapsorted_entry_set_top hses_checker u_hses_checker (.*);
`default_nettype wire

// ===== verif/heapsorted_entry_set_top_test.sv =====
`default_nettype none
module heapsorted_entry_set_top_test;
   import hses_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [OP_W-1:0]     req_op = '0;
   logic [ENTRY_W-1:0]  req_entry = '0;
   wire                 busy;
   wire                 rsp_valid;
   wire [STATUS_W-1:0]  rsp_status;
   wire [ENTRY_W-1:0]   rsp_entry_out;
   wire [COUNT_W-1:0]   rsp_member_count;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [ENTRY_W-1:0] entry;
   } cmd_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  entry_out;
      logic [COUNT_W-1:0]  member_count;
   } rsp_word_type;

   cmd_word_type pending_cmds[$];
   rsp_word_type awaited_rsps[$];
   int        error_count = 0;
   bit        calm = 1'b0;
   int        gap_left = 0;

   // Predictor state: set membership only; the sorted order follows from it
   bit        member[ENTRY_SPACE];
   int        set_size = 0;

   heapsorted_entry_set_top dut (.*);

   always #2 clock = ~clock;

   // Work out the response a command word produces and update the set
   function automatic rsp_word_type predict_set_op(cmd_word_type c);
      rsp_word_type r;
      int        k;
      r = '0;
      case (c.op)
         OP_ADD: begin
            if (int'(c.entry) >= ENTRY_SPACE) r.status = ST_RANGE;
            else if (member[c.entry]) r.status = ST_DUP;
            else if (set_size >= MAX_ENTRIES) r.status = ST_FULL;
            else begin
               member[c.entry] = 1'b1;
               set_size++;
            end
         end
         OP_CLEAR: begin
            foreach (member[i]) member[i] = 1'b0;
            set_size = 0;
         end
         OP_FIRST, OP_LAST: begin
            r.status = ST_NONE;
            for (k = 0; k < ENTRY_SPACE; k++) begin
               if (member[k]) begin
                  r.status = ST_OK;
                  r.entry_out = ENTRY_W'(k);
                  if (c.op == OP_FIRST) break;
               end
            end
         end
         OP_PREV, OP_NEXT: begin
            r.status = ST_NONE;
            if (int'(c.entry) >= ENTRY_SPACE) r.status = ST_RANGE;
            else if (member[c.entry]) begin
               if (c.op == OP_PREV) begin
                  for (k = int'(c.entry) - 1; k >= 0; k--)
                     if (member[k]) begin
                        r.status = ST_OK;
                        r.entry_out = ENTRY_W'(k);
                        break;
                     end
               end else begin
                  for (k = int'(c.entry) + 1; k < ENTRY_SPACE; k++)
                     if (member[k]) begin
                        r.status = ST_OK;
                        r.entry_out = ENTRY_W'(k);
                        break;
                     end
               end
            end
         end
         default: ;
      endcase
      r.member_count = COUNT_W'(set_size);
      return r;
   endfunction

   // Driver: random gaps in bursts, a word held until taken
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            awaited_rsps = {awaited_rsps, predict_set_op({req_op, req_entry})};
         end
         if (start && busy) begin
            // still waiting for the block to take the word
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0 && !calm && $urandom_range(0, 15) == 0) begin
            gap_left <= $urandom_range(1, 11);
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            cmd_word_type c;
            c = pending_cmds.pop_front();
            req_op <= c.op;
            req_entry <= c.entry;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_rsps.size() == 0) begin
            $error("response with none awaited");
            error_count++;
         end else begin
            rsp_word_type e;
            e = awaited_rsps.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_out !== e.entry_out) begin
               $error("entry_out expected %0d actual %0d", e.entry_out, rsp_entry_out);
               error_count++;
            end
            if (rsp_member_count !== e.member_count) begin
               $error("member_count expected %0d actual %0d",
                      e.member_count, rsp_member_count);
               error_count++;
            end
         end
      end
   end

   task automatic queue_cmd(logic [OP_W-1:0] op, logic [ENTRY_W-1:0] entry);
      pending_cmds = {pending_cmds, cmd_word_type'{op, entry}};
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || start || awaited_rsps.size() > 0)
         @(posedge clock);
   endtask

   // Burst: maybe a clear, then adds from a narrow window mixed with queries
   task automatic queue_random_burst(int n);
      int base;
      int span;
      int r;
      base = $urandom_range(0, ENTRY_SPACE - 1);
      span = $urandom_range(1, 64);
      if ($urandom_range(0, 3) == 0) queue_cmd(OP_CLEAR, ENTRY_W'($urandom));
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            queue_cmd(OP_ADD, ENTRY_W'((base + $urandom_range(0, span)) % ENTRY_SPACE));
         else if (r < 85)
            queue_cmd($urandom_range(0, 1) ? OP_PREV : OP_NEXT,
                      ENTRY_W'((base + $urandom_range(0, span)) % ENTRY_SPACE));
         else if (r < 95)
            queue_cmd(OP_W'($urandom_range(OP_FIRST, OP_LAST)), ENTRY_W'($urandom));
         else
            queue_cmd(OP_W'($urandom_range(0, 7)), ENTRY_W'($urandom));
      end
   endtask

   initial begin
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty set, extremes, duplicates, unsorted neighbours, spare ops
      queue_cmd(OP_FIRST, 0);
      queue_cmd(OP_LAST, 0);
      queue_cmd(OP_NEXT, 12'hFFF);
      queue_cmd(OP_ADD, 12'hFFF);
      queue_cmd(OP_ADD, 0);
      queue_cmd(OP_ADD, 12'h555);
      queue_cmd(OP_ADD, 12'hAAA);
      queue_cmd(OP_ADD, 12'h555);
      queue_cmd(OP_NEXT, 0);
      queue_cmd(OP_PREV, 12'hFFF);
      queue_cmd(OP_PREV, 0);
      queue_cmd(OP_NEXT, 12'hFFF);
      queue_cmd(OP_PREV, 12'h123);
      queue_cmd(OP_FIRST, 0);
      queue_cmd(OP_LAST, 0);
      queue_cmd(3'd6, 12'hFFF);
      queue_cmd(3'd7, 0);
      queue_cmd(OP_CLEAR, 0);
      queue_cmd(OP_LAST, 0);
      wait_drained();

      // Fill to capacity, hit the full case, then walk it
      for (i = 0; i < MAX_ENTRIES; i++)
         queue_cmd(OP_ADD, ENTRY_W'((i * 7 + 3) % ENTRY_SPACE));
      queue_cmd(OP_ADD, 12'hFFE);
      queue_cmd(OP_ADD, 3);
      queue_cmd(OP_NEXT, 3);
      queue_cmd(OP_PREV, ENTRY_W'(12'hFFF & (1023 * 7 + 3)));
      queue_cmd(OP_LAST, 0);
      queue_cmd(OP_CLEAR, 0);
      wait_drained();

      // Random bursts
      for (i = 0; i < 8; i++) queue_random_burst($urandom_range(4, 30));
      wait_drained();
      calm = 1'b1;
      for (i = 0; i < 5; i++) queue_random_burst($urandom_range(4, 20));
      wait_drained();
      repeat (20000) @(posedge clock);
      if (error_count == 0 && awaited_rsps.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
